### rtl/sync_xor_frame_receiver_unit_defines.svh
// Assertion macros used by the frame receiver checker.
`ifndef SYNC_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SXFR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sxfr assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SXFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sxfr assertion failed");

`endif

### rtl/sxfr_pkg.sv
// Shared types and constants of the sync XOR frame receiver.
`default_nettype none

package sxfr_pkg;

	localparam int BYTE_W  = 8;
	localparam int FLEN_W  = 7;
	localparam int INDEX_W = 6;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [BYTE_W-1:0]    byte_t;

	localparam cfg_idx_t CFG_FIRST_SYNC   = 2'd0;
	localparam cfg_idx_t CFG_SECOND_SYNC  = 2'd1;
	localparam cfg_idx_t CFG_FRAME_LENGTH = 2'd2;

	localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 7'd4;

endpackage

`default_nettype wire

### rtl/sxfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sxfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/sync_xor_frame_receiver_unit.sv
// Top level of the two-sync-byte, fixed-length frame receiver with XOR check.
// Usage:
//  - in channel (in_valid/in_ready, rx_byte): one received byte per transaction.
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes first_sync,
//    second_sync, frame_length; always ready, write only while idle.
//  - out channel (out_valid/out_ready, frame_byte, byte_index, last): the
//    bytes of a frame whose check byte matched, index 0 first, last on the
//    check byte. A failed frame produces nothing.
// Throughput: one input byte per cycle while hunting and collecting.
// After a good check byte, in_ready drops while the frame is read back from
// the frame store RAM: one RAM read per output byte, each read issued only
// when the output register is free and no earlier read is pending. The
// first byte follows the check byte transaction through drain_q, the RAM
// read and output register. in_ready returns once the last read is issued.
// A stalled out_ready holds the output register and pauses the reads.
// Reset clears the parser to hunting, the registers to their defaults and
// the output to empty; the RAM is not cleared.
`default_nettype none

module sync_xor_frame_receiver_unit
	import sxfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [BYTE_W-1:0]    frame_byte,
	output logic      [INDEX_W-1:0]   byte_index,
	output logic                      last,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int CMPW = (AW + 1 > FLEN_W) ? AW + 1 : FLEN_W;

	typedef enum logic [1:0] {
		ST_HUNT1,
		ST_HUNT2,
		ST_DATA,
		ST_CHECK
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       count_q;
	byte_t               xor_q;
	byte_t               first_sync_q;
	byte_t               second_sync_q;
	logic [FLEN_W-1:0]   frame_length_q;

	logic                drain_q;
	logic [AW-1:0]       rd_idx_q;
	logic [AW-1:0]       rd_last_q;
	logic                pend_s1;
	logic [AW-1:0]       idx_s1;
	logic                last_s1;

	logic                out_valid_q;
	byte_t               frame_byte_q;
	logic [INDEX_W-1:0]  byte_index_q;
	logic                last_q;

	logic                in_fire;
	logic                rd_issue;
	logic                we;
	logic [AW-1:0]       waddr;
	byte_t               rdata;
	logic [CMPW-1:0]     count_ext;
	logic                store_full;
	logic                data_done;
	logic                rd_at_last;

	assign in_ready   = !drain_q;
	assign cfg_ready  = 1'b1;
	assign in_fire    = in_valid && in_ready;
	assign rd_issue   = drain_q && !pend_s1 && (!out_valid_q || out_ready);
	assign rd_at_last = (rd_idx_q == rd_last_q);

	assign count_ext  = CMPW'(count_q);
	assign store_full = count_ext >= CMPW'(BUFFER_DEPTH - 1);
	assign data_done  = (count_ext + CMPW'(2)) >= CMPW'(frame_length_q);

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign byte_index = byte_index_q;
	assign last       = last_q;

	always_comb begin
		we    = 1'b0;
		waddr = count_q;
		case (state_q)
			ST_HUNT1: begin
				we    = in_fire;
				waddr = '0;
			end
			ST_HUNT2: we = in_fire && (rx_byte == second_sync_q);
			ST_DATA:  we = in_fire && !store_full;
			ST_CHECK: we = in_fire;
			default:  we = 1'b0;
		endcase
	end

	sxfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(rx_byte),
		.re   (rd_issue),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_HUNT1;
			count_q        <= '0;
			xor_q          <= '0;
			first_sync_q   <= '0;
			second_sync_q  <= '0;
			frame_length_q <= FRAME_LENGTH_RESET;
			drain_q        <= 1'b0;
			rd_idx_q       <= '0;
			rd_last_q      <= '0;
			pend_s1        <= 1'b0;
			idx_s1         <= '0;
			last_s1        <= 1'b0;
			out_valid_q    <= 1'b0;
			frame_byte_q   <= '0;
			byte_index_q   <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FIRST_SYNC:   first_sync_q   <= cfg_data;
					CFG_SECOND_SYNC:  second_sync_q  <= cfg_data;
					CFG_FRAME_LENGTH: frame_length_q <= cfg_data[FLEN_W-1:0];
					default:          ;
				endcase
			end

			if (in_fire) begin
				case (state_q)
					ST_HUNT1: begin
						if (rx_byte == first_sync_q) begin
							count_q <= AW'(1);
							xor_q   <= rx_byte;
							state_q <= ST_HUNT2;
						end else begin
							count_q <= '0;
							xor_q   <= '0;
						end
					end
					ST_HUNT2: begin
						if (rx_byte == second_sync_q) begin
							count_q <= count_q + AW'(1);
							xor_q   <= xor_q ^ rx_byte;
							state_q <= ST_DATA;
						end else begin
							state_q <= ST_HUNT1;
						end
					end
					ST_DATA: begin
						if (store_full) begin
							state_q <= ST_HUNT1;
						end else begin
							count_q <= count_q + AW'(1);
							xor_q   <= xor_q ^ rx_byte;
							if (data_done) begin
								state_q <= ST_CHECK;
							end
						end
					end
					ST_CHECK: begin
						if (xor_q == rx_byte) begin
							drain_q   <= 1'b1;
							rd_idx_q  <= '0;
							rd_last_q <= count_q;
						end
						state_q <= ST_HUNT1;
					end
					default: state_q <= ST_HUNT1;
				endcase
			end

			// read-back of an accepted frame
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
				if (rd_at_last) begin
					drain_q <= 1'b0;
				end
			end
			pend_s1 <= rd_issue;
			idx_s1  <= rd_idx_q;
			last_s1 <= rd_at_last;

			if (pend_s1) begin
				out_valid_q  <= 1'b1;
				frame_byte_q <= rdata;
				byte_index_q <= INDEX_W'(idx_s1);
				last_q       <= last_s1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/sxfr_checker.sv
// Port-level assertion checker for the frame receiver, bound to the top level.
`default_nettype none
`include "sync_xor_frame_receiver_unit_defines.svh"

module sxfr_checker
	import sxfr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic [BYTE_W-1:0]    rx_byte,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [BYTE_W-1:0]    frame_byte,
	input wire logic [INDEX_W-1:0]   byte_index,
	input wire logic                 last,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [BYTE_W-1:0]    cfg_data
);

	logic unused_ok;
	assign unused_ok = ^{rx_byte, in_valid, cfg_valid, cfg_index, cfg_data};

	// stalled output transaction holds
	`SXFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last))

	// register writes are never held off
	`SXFR_ASSERT_IMPL(a_cfg_always_ready, 1'b1, cfg_ready)

	// a fresh frame start arrives while the input side is held off
	`SXFR_ASSERT_IMPL(a_start_blocks_in, out_valid && !$past(out_valid) && (byte_index == '0) && !last, !in_ready)

endmodule

bind sync_xor_frame_receiver_unit sxfr_checker u_sxfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.rx_byte   (rx_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.frame_byte(frame_byte),
	.byte_index(byte_index),
	.last      (last),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

`default_nettype wire
